[rtl/taf_pkg.sv]
// Shared types and codes for the ticketed admission FIFO.
package taf_pkg;

	// Request operation codes.
	typedef enum logic [1:0] {
		OP_ENTER       = 2'd0,
		OP_EXIT        = 2'd1,
		OP_FORCE_ENTER = 2'd2,
		OP_FORCE_EXIT  = 2'd3
	} op_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_TICKET     = 3'd0,
		ST_ADMIT      = 3'd1,
		ST_QUEUED     = 3'd2,
		ST_ADMIT_FULL = 3'd3,
		ST_INSIDE     = 3'd4,
		ST_NOCHANGE   = 3'd5,
		ST_EXITED     = 3'd6
	} status_t;

	// Configuration register indexes.
	localparam logic REG_LIMIT   = 1'b0;
	localparam logic REG_TICKETS = 1'b1;

	// Depth of the command queue between front and back.
	localparam int QDEPTH = 2;
	localparam int QPW    = 1;

	// Classified request handed from front to back.
	typedef struct packed {
		op_t        op;
		logic       nop;
		logic [5:0] client;
	} cmd_t;

endpackage

[rtl/taf_front.sv]
// Front end: accepts requests and classifies them into commands.
module taf_front #(
	parameter int MAX_CLIENTS = 64
) (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        operation,
	input  logic [5:0]        client_id,
	input  logic              is_bypass,
	input  logic              q_full,
	output logic              q_push,
	output taf_pkg::cmd_t     q_cmd
);

	logic [31:0] client32;

	// A request is taken whenever the command queue has room.
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// Bypass clients and clients beyond the table never change state.
	always_comb begin
		client32     = 32'(client_id);
		q_cmd.op     = taf_pkg::op_t'(operation);
		q_cmd.client = client_id;
		q_cmd.nop    = is_bypass || (client32 >= 32'(MAX_CLIENTS));
	end

endmodule

[rtl/taf_cmd_queue.sv]
// Short command queue that decouples the front end from the back end.
module taf_cmd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  taf_pkg::cmd_t     push_cmd,
	input  logic              pop,
	output taf_pkg::cmd_t     head_cmd,
	output logic              not_empty,
	output logic              full
);

	taf_pkg::cmd_t                entry_q [taf_pkg::QDEPTH];
	logic [taf_pkg::QPW-1:0]      wr_ptr_q;
	logic [taf_pkg::QPW-1:0]      rd_ptr_q;
	logic [taf_pkg::QPW:0]        count_q;

	assign head_cmd  = entry_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == (taf_pkg::QPW+1)'(taf_pkg::QDEPTH));

	// Storage for queued commands.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/taf_back.sv]
// Back end: reads client state, applies each command and registers the result.
module taf_back #(
	parameter int MAX_CLIENTS = 64,
	parameter int TICKET_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  taf_pkg::cmd_t          q_cmd,
	input  logic                   q_valid,
	output logic                   q_pop,
	input  logic [7:0]             limit,
	input  logic [TICKET_BITS-1:0] free_tickets,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [2:0]             status,
	output logic                   released_valid,
	output logic [5:0]             released_client,
	output logic [6:0]             inside_count,
	output logic [6:0]             waiting_count
);

	localparam int CW   = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
	localparam int IW   = $clog2(MAX_CLIENTS + 1);
	localparam int CMPW = (IW > 8) ? IW : 8;

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_EXEC = 2'b10
	} bk_state_t;

	bk_state_t state_q;

	// Per-client tickets and the wait queue storage.
	logic [TICKET_BITS-1:0] tkt_mem [MAX_CLIENTS];
	logic [CW-1:0]          wq_mem  [MAX_CLIENTS];

	// Per-client flags; an entry of the ticket table counts only while inside.
	logic [MAX_CLIENTS-1:0] inside_q;
	logic [MAX_CLIENTS-1:0] waiting_q;
	logic [CW-1:0]          head_q;
	logic [CW-1:0]          tail_q;
	logic [IW-1:0]          fill_q;
	logic [IW-1:0]          total_q;

	// Command and memory read data held for the execute cycle.
	taf_pkg::cmd_t          cmd_s1;
	logic [CW-1:0]          idx_s1;
	logic [TICKET_BITS-1:0] tkt_rd_s1;
	logic [CW-1:0]          head_rd_s1;

	// Result register.
	logic                   out_valid_q;
	taf_pkg::status_t       status_q;
	logic                   rel_valid_q;
	logic [5:0]             rel_client_q;
	logic [6:0]             inside_cnt_q;
	logic [6:0]             waiting_cnt_q;

	// Execute-cycle decisions.
	logic [31:0]            q_client32;
	logic [CW-1:0]          q_idx;
	logic                   done;
	logic [TICKET_BITS-1:0] tkt;
	logic                   in_c;
	logic                   wait_c;
	logic                   room;
	logic                   room_dec;
	logic                   fifo_full;
	logic [IW-1:0]          total_dec;
	taf_pkg::status_t       status_n;
	logic                   rel_n;
	logic                   set_in;
	logic                   clr_in;
	logic                   enq;
	logic                   deq;
	logic                   tkt_we;
	logic [CW-1:0]          tkt_waddr;
	logic [TICKET_BITS-1:0] tkt_wdata;
	logic [IW-1:0]          total_n;
	logic [IW-1:0]          fill_n;
	logic [31:0]            total32;
	logic [31:0]            fill32;
	logic [31:0]            rel32;

	// Table index of the command at the queue head.
	always_comb begin
		q_client32 = 32'(q_cmd.client);
		q_idx      = q_client32[CW-1:0];
	end

	assign q_pop = (state_q == BK_IDLE) && q_valid;
	assign done  = (state_q == BK_EXEC) && (!out_valid_q || out_ready);

	// Sequencer: take a command, then apply it once the result register is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			case (state_q)
				BK_IDLE: begin
					if (q_valid) begin
						state_q <= BK_EXEC;
					end
				end
				BK_EXEC: begin
					if (done) begin
						state_q <= BK_IDLE;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	// Latch the command and read both memories when it is taken.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1     <= q_cmd;
			idx_s1     <= q_idx;
			tkt_rd_s1  <= tkt_mem[q_idx];
			head_rd_s1 <= wq_mem[head_q];
		end
	end

	// Ticket table write port.
	always_ff @(posedge clk) begin
		if (done && tkt_we) begin
			tkt_mem[tkt_waddr] <= tkt_wdata;
		end
	end

	// Wait queue write port.
	always_ff @(posedge clk) begin
		if (done && enq) begin
			wq_mem[tail_q] <= idx_s1;
		end
	end

	// Decide what the command does.
	always_comb begin
		tkt       = inside_q[idx_s1] ? tkt_rd_s1 : '0;
		in_c      = inside_q[idx_s1];
		wait_c    = waiting_q[idx_s1];
		room      = CMPW'(total_q) < CMPW'(limit);
		fifo_full = (fill_q == IW'(MAX_CLIENTS));
		total_dec = (total_q != '0) ? total_q - 1'b1 : total_q;
		room_dec  = CMPW'(total_dec) < CMPW'(limit);

		status_n  = taf_pkg::ST_NOCHANGE;
		rel_n     = 1'b0;
		set_in    = 1'b0;
		clr_in    = 1'b0;
		enq       = 1'b0;
		deq       = 1'b0;
		tkt_we    = 1'b0;
		tkt_waddr = idx_s1;
		tkt_wdata = free_tickets;
		total_n   = total_q;

		if (!cmd_s1.nop) begin
			case (cmd_s1.op)
				taf_pkg::OP_ENTER: begin
					if (tkt != '0) begin
						tkt_we    = 1'b1;
						tkt_wdata = tkt - 1'b1;
						status_n  = taf_pkg::ST_TICKET;
					end else if (limit == '0 || wait_c) begin
						status_n = taf_pkg::ST_NOCHANGE;
					end else if (in_c) begin
						status_n = taf_pkg::ST_INSIDE;
					end else if (room) begin
						set_in   = 1'b1;
						tkt_we   = 1'b1;
						total_n  = total_q + 1'b1;
						status_n = taf_pkg::ST_ADMIT;
					end else if (!fifo_full) begin
						enq      = 1'b1;
						status_n = taf_pkg::ST_QUEUED;
					end else begin
						set_in    = 1'b1;
						tkt_we    = 1'b1;
						tkt_wdata = '0;
						total_n   = total_q + 1'b1;
						status_n  = taf_pkg::ST_ADMIT_FULL;
					end
				end
				taf_pkg::OP_FORCE_ENTER: begin
					if (limit == '0 || wait_c) begin
						status_n = taf_pkg::ST_NOCHANGE;
					end else if (in_c) begin
						status_n = taf_pkg::ST_INSIDE;
					end else begin
						set_in    = 1'b1;
						tkt_we    = 1'b1;
						tkt_wdata = TICKET_BITS'(1);
						total_n   = total_q + 1'b1;
						status_n  = taf_pkg::ST_ADMIT;
					end
				end
				taf_pkg::OP_EXIT, taf_pkg::OP_FORCE_EXIT: begin
					if ((cmd_s1.op == taf_pkg::OP_EXIT && tkt != '0) || !in_c) begin
						status_n = taf_pkg::ST_NOCHANGE;
					end else begin
						clr_in   = 1'b1;
						total_n  = total_dec;
						status_n = taf_pkg::ST_EXITED;
						// Room freed up: admit the client at the queue head.
						if (room_dec && fill_q != '0) begin
							deq       = 1'b1;
							rel_n     = 1'b1;
							tkt_we    = 1'b1;
							tkt_waddr = head_rd_s1;
							total_n   = total_dec + 1'b1;
						end
					end
				end
				default: status_n = taf_pkg::ST_NOCHANGE;
			endcase
		end

		if (enq) begin
			fill_n = fill_q + 1'b1;
		end else if (deq) begin
			fill_n = fill_q - 1'b1;
		end else begin
			fill_n = fill_q;
		end

		total32 = 32'(total_n);
		fill32  = 32'(fill_n);
		rel32   = 32'(head_rd_s1);
	end

	// Flags, queue pointers and counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q  <= '0;
			waiting_q <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			fill_q    <= '0;
			total_q   <= '0;
		end else if (done) begin
			if (set_in) begin
				inside_q[idx_s1] <= 1'b1;
			end
			if (clr_in) begin
				inside_q[idx_s1] <= 1'b0;
			end
			if (enq) begin
				waiting_q[idx_s1] <= 1'b1;
				tail_q <= (tail_q == CW'(MAX_CLIENTS - 1)) ? '0 : tail_q + 1'b1;
			end
			if (deq) begin
				waiting_q[head_rd_s1] <= 1'b0;
				inside_q[head_rd_s1]  <= 1'b1;
				head_q <= (head_q == CW'(MAX_CLIENTS - 1)) ? '0 : head_q + 1'b1;
			end
			fill_q  <= fill_n;
			total_q <= total_n;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (done) begin
			status_q      <= status_n;
			rel_valid_q   <= rel_n;
			rel_client_q  <= rel_n ? rel32[5:0] : 6'd0;
			inside_cnt_q  <= total32[6:0];
			waiting_cnt_q <= fill32[6:0];
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign released_valid  = rel_valid_q;
	assign released_client = rel_client_q;
	assign inside_count    = inside_cnt_q;
	assign waiting_count   = waiting_cnt_q;

endmodule

[rtl/ticketed_admission_fifo_top.sv]
// An accepted request is written into the command queue, then latched by the back end with its
// memory reads, then applied into the result register once it is free (out_valid high after it).
// The back end takes a new command only after the last is applied: it reads both memories, then writes them.
// A two-entry command queue lets requests be accepted while a result waits to be taken.
// Reset: arst_n clears all flags, queue pointers and counts at once; limit resets to 0
// and the ticket grant to 500. No clearing pass is needed after reset.
module ticketed_admission_fifo_top #(
	parameter int MAX_CLIENTS = 64,
	parameter int TICKET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [15:0] wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [5:0]  client_id,
	input  logic        is_bypass,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        released_valid,
	output logic [5:0]  released_client,
	output logic [6:0]  inside_count,
	output logic [6:0]  waiting_count
);

	localparam logic [31:0] TICKETS_RESET = 32'd500;

	logic [7:0]             limit_q;
	logic [TICKET_BITS-1:0] free_q;
	logic [31:0]            wr_data32;

	taf_pkg::cmd_t          push_cmd;
	taf_pkg::cmd_t          head_cmd;
	logic                   push;
	logic                   pop;
	logic                   q_full;
	logic                   q_not_empty;

	assign wr_data32 = 32'(wr_data);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
			free_q  <= TICKETS_RESET[TICKET_BITS-1:0];
		end else if (wr_en) begin
			case (wr_index)
				taf_pkg::REG_LIMIT:   limit_q <= wr_data[7:0];
				taf_pkg::REG_TICKETS: free_q  <= wr_data32[TICKET_BITS-1:0];
				default: ;
			endcase
		end
	end

	taf_front #(
		.MAX_CLIENTS(MAX_CLIENTS)
	) u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.client_id (client_id),
		.is_bypass (is_bypass),
		.q_full    (q_full),
		.q_push    (push),
		.q_cmd     (push_cmd)
	);

	taf_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.head_cmd  (head_cmd),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	taf_back #(
		.MAX_CLIENTS(MAX_CLIENTS),
		.TICKET_BITS(TICKET_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_cmd           (head_cmd),
		.q_valid         (q_not_empty),
		.q_pop           (pop),
		.limit           (limit_q),
		.free_tickets    (free_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.released_valid  (released_valid),
		.released_client (released_client),
		.inside_count    (inside_count),
		.waiting_count   (waiting_count)
	);

endmodule

[test/ticketed_admission_fifo_top_tb.sv]
// Self-checking testbench for the ticketed admission FIFO top level.
module ticketed_admission_fifo_top_tb;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 4;

	// Expected response to one request.
	typedef struct {
		taf_pkg::status_t status;
		logic             rel_valid;
		logic [5:0]       rel_client;
		logic [6:0]       inside_cnt;
		logic [6:0]       waiting;
	} admission_result_t;

	logic        clk;
	logic        arst_n          = 1'b0;
	logic        wr_en           = 1'b0;
	logic        wr_index        = taf_pkg::REG_LIMIT;
	logic [15:0] wr_data         = 16'd0;
	logic        in_valid        = 1'b0;
	logic        in_ready;
	logic [1:0]  operation       = taf_pkg::OP_ENTER;
	logic [5:0]  client_id       = 6'd0;
	logic        is_bypass       = 1'b0;
	logic        out_valid;
	logic        out_ready       = 1'b1;
	logic [2:0]  status;
	logic        released_valid;
	logic [5:0]  released_client;
	logic [6:0]  inside_count;
	logic [6:0]  waiting_count;

	// Shadow copy of the admission state and its configuration.
	logic [7:0]  cfg_limit;
	logic [15:0] cfg_grant;
	logic [15:0] ticket_shadow [64];
	logic        inside_shadow [64];
	logic        waiting_shadow [64];
	logic [5:0]  wait_line [64];
	logic [5:0]  line_head;
	logic [5:0]  line_tail;
	logic [6:0]  line_fill;
	logic [6:0]  admitted_total;

	admission_result_t pending_results [$];
	int mismatch_count     = 0;
	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;

	ticketed_admission_fifo_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.client_id       (client_id),
		.is_bypass       (is_bypass),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.released_valid  (released_valid),
		.released_client (released_client),
		.inside_count    (inside_count),
		.waiting_count   (waiting_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Count a client inside and hand it its tickets.
	function automatic void admit_client(logic [5:0] cid, logic [15:0] tix);
		inside_shadow[cid] = 1'b1;
		ticket_shadow[cid] = tix;
		admitted_total++;
	endfunction

	// Apply one request to the shadow state and return the response it must produce.
	function automatic admission_result_t predict_admission(taf_pkg::op_t op,
			logic [5:0] cid, logic byp);
		admission_result_t res;
		logic [5:0] head_client;
		res = '{status: taf_pkg::ST_NOCHANGE, rel_valid: 1'b0, rel_client: 6'd0,
			inside_cnt: 7'd0, waiting: 7'd0};
		if (!byp) begin
			case (op)
				taf_pkg::OP_ENTER: begin
					if (ticket_shadow[cid] != 16'd0) begin
						ticket_shadow[cid]--;
						res.status = taf_pkg::ST_TICKET;
					end else if (cfg_limit == 8'd0 || waiting_shadow[cid]) begin
						res.status = taf_pkg::ST_NOCHANGE;
					end else if (inside_shadow[cid]) begin
						res.status = taf_pkg::ST_INSIDE;
					end else if ({1'b0, admitted_total} < cfg_limit) begin
						admit_client(cid, cfg_grant);
						res.status = taf_pkg::ST_ADMIT;
					end else if (line_fill < 7'd64) begin
						wait_line[line_tail] = cid;
						line_tail++;
						line_fill++;
						waiting_shadow[cid] = 1'b1;
						res.status = taf_pkg::ST_QUEUED;
					end else begin
						admit_client(cid, 16'd0);
						res.status = taf_pkg::ST_ADMIT_FULL;
					end
				end
				taf_pkg::OP_FORCE_ENTER: begin
					if (cfg_limit == 8'd0 || waiting_shadow[cid])
						res.status = taf_pkg::ST_NOCHANGE;
					else if (inside_shadow[cid])
						res.status = taf_pkg::ST_INSIDE;
					else begin
						admit_client(cid, 16'd1);
						res.status = taf_pkg::ST_ADMIT;
					end
				end
				default: begin
					if ((op == taf_pkg::OP_EXIT && ticket_shadow[cid] != 16'd0) ||
							!inside_shadow[cid]) begin
						res.status = taf_pkg::ST_NOCHANGE;
					end else begin
						inside_shadow[cid] = 1'b0;
						ticket_shadow[cid] = 16'd0;
						if (admitted_total != 7'd0)
							admitted_total--;
						// Room opened up: the head of the wait line goes in at once.
						if ({1'b0, admitted_total} < cfg_limit && line_fill != 7'd0) begin
							head_client = wait_line[line_head];
							line_head++;
							line_fill--;
							waiting_shadow[head_client] = 1'b0;
							admit_client(head_client, cfg_grant);
							res.rel_valid  = 1'b1;
							res.rel_client = head_client;
						end
						res.status = taf_pkg::ST_EXITED;
					end
				end
			endcase
		end
		res.inside_cnt = admitted_total;
		res.waiting    = line_fill;
		return res;
	endfunction

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	// Receiver side: random backpressure on the response channel.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Predict on every accepted request and check every accepted response.
	always @(posedge clk) begin
		admission_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					note_mismatch($sformatf("response with no request pending: status=%0d",
						status));
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status || released_valid !== want.rel_valid ||
							released_client !== want.rel_client ||
							inside_count !== want.inside_cnt ||
							waiting_count !== want.waiting)
						note_mismatch($sformatf({"expected status=%0d rel=%0b/%0d inside=%0d ",
							"waiting=%0d, got status=%0d rel=%0b/%0d inside=%0d waiting=%0d"},
							want.status, want.rel_valid, want.rel_client, want.inside_cnt,
							want.waiting, status, released_valid, released_client,
							inside_count, waiting_count));
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(predict_admission(taf_pkg::op_t'(operation),
					client_id, is_bypass));
		end
	end

	// Watchdog: end the run when neither channel nor the write port moves for too long.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || wr_en)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("ticketed_admission_fifo_top: mismatch");
		$finish;
	end

	// Present one request and hold it until it is accepted; valid stays high on return.
	task automatic send_request(input taf_pkg::op_t op, input logic [5:0] cid,
			input logic byp);
		if ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid  <= 1'b1;
		operation <= op;
		client_id <= cid;
		is_bypass <= byp;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop sending and wait until every pending response has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register while the block is idle and mirror it in the shadow copy.
	task automatic write_register(input logic idx, input logic [15:0] data);
		drain_results();
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == taf_pkg::REG_LIMIT)
			cfg_limit = data[7:0];
		else
			cfg_grant = data;
	endtask

	task automatic set_limit(input logic [7:0] limit);
		// Upper data bits are random; only the low byte belongs to the limit.
		write_register(taf_pkg::REG_LIMIT, {8'($urandom_range(255)), limit});
	endtask

	// Bypass requests and requests while counting is disabled leave everything alone.
	task automatic test_bypass();
		send_request(taf_pkg::OP_ENTER, 6'd63, 1'b1);
		send_request(taf_pkg::OP_EXIT, 6'd0, 1'b1);
		send_request(taf_pkg::OP_FORCE_ENTER, 6'd42, 1'b1);
		send_request(taf_pkg::OP_FORCE_EXIT, 6'd21, 1'b1);
		send_request(taf_pkg::OP_ENTER, 6'd5, 1'b0);
		send_request(taf_pkg::OP_FORCE_ENTER, 6'd5, 1'b0);
	endtask

	// Inside clients without tickets, then a forced exit with counting disabled.
	task automatic test_limit_zero();
		set_limit(8'd2);
		write_register(taf_pkg::REG_TICKETS, 16'd0);
		send_request(taf_pkg::OP_ENTER, 6'd0, 1'b0);
		send_request(taf_pkg::OP_ENTER, 6'd0, 1'b0);
		send_request(taf_pkg::OP_FORCE_ENTER, 6'd0, 1'b0);
		set_limit(8'd0);
		send_request(taf_pkg::OP_FORCE_EXIT, 6'd0, 1'b0);
		send_request(taf_pkg::OP_EXIT, 6'd1, 1'b0);
	endtask

	// Queueing, requests from queued clients, and release of the queue head.
	task automatic test_queue_release();
		set_limit(8'd1);
		write_register(taf_pkg::REG_TICKETS, 16'd2);
		send_request(taf_pkg::OP_ENTER, 6'd10, 1'b0);
		send_request(taf_pkg::OP_ENTER, 6'd11, 1'b0);
		send_request(taf_pkg::OP_ENTER, 6'd11, 1'b0);
		send_request(taf_pkg::OP_FORCE_ENTER, 6'd11, 1'b0);
		send_request(taf_pkg::OP_ENTER, 6'd12, 1'b0);
		send_request(taf_pkg::OP_EXIT, 6'd10, 1'b0);
		send_request(taf_pkg::OP_ENTER, 6'd10, 1'b0);
		send_request(taf_pkg::OP_FORCE_EXIT, 6'd10, 1'b0);
		send_request(taf_pkg::OP_FORCE_EXIT, 6'd63, 1'b0);
		send_request(taf_pkg::OP_FORCE_ENTER, 6'd63, 1'b0);
		send_request(taf_pkg::OP_EXIT, 6'd11, 1'b0);
		send_request(taf_pkg::OP_ENTER, 6'd11, 1'b0);
		send_request(taf_pkg::OP_ENTER, 6'd11, 1'b0);
		send_request(taf_pkg::OP_EXIT, 6'd11, 1'b0);
		send_request(taf_pkg::OP_FORCE_EXIT, 6'd63, 1'b0);
	endtask

	// Largest limit and ticket grant.
	task automatic test_ticket_extremes();
		set_limit(8'd255);
		write_register(taf_pkg::REG_TICKETS, 16'hFFFF);
		send_request(taf_pkg::OP_ENTER, 6'd33, 1'b0);
		send_request(taf_pkg::OP_ENTER, 6'd33, 1'b0);
		send_request(taf_pkg::OP_EXIT, 6'd33, 1'b0);
		send_request(taf_pkg::OP_FORCE_EXIT, 6'd33, 1'b0);
	endtask

	// Random traffic under one setting; the sender pauses to drain halfway through.
	task automatic test_random_traffic(input int count, input logic [7:0] limit,
			input logic [15:0] grant, input int pool, input int idle_pct, input int stall_pct);
		int           pick;
		taf_pkg::op_t op;
		set_limit(limit);
		write_register(taf_pkg::REG_TICKETS, grant);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				drain_results();
			pick = $urandom_range(99);
			if (pick < 45)
				op = taf_pkg::OP_ENTER;
			else if (pick < 62)
				op = taf_pkg::OP_EXIT;
			else if (pick < 75)
				op = taf_pkg::OP_FORCE_ENTER;
			else
				op = taf_pkg::OP_FORCE_EXIT;
			send_request(op, 6'($urandom_range(pool - 1)), $urandom_range(19) == 0);
		end
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
	endtask

	// Test sequence.
	initial begin
		cfg_limit      = 8'd0;
		cfg_grant      = 16'd500;
		line_head      = 6'd0;
		line_tail      = 6'd0;
		line_fill      = 7'd0;
		admitted_total = 7'd0;
		for (int i = 0; i < 64; i++) begin
			ticket_shadow[i]  = 16'd0;
			inside_shadow[i]  = 1'b0;
			waiting_shadow[i] = 1'b0;
			wait_line[i]      = 6'd0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_bypass();
		test_limit_zero();
		test_queue_release();
		test_ticket_extremes();
		test_random_traffic(85, 8'd1, 16'd0, 64, 0, 0);
		test_random_traffic(85, 8'd3, 16'd2, 8, 68, 0);
		test_random_traffic(85, 8'd255, 16'hFFFF, 64, 0, 68);
		test_random_traffic(85, 8'd0, 16'd1, 8, 33, 33);
		test_random_traffic(85, 8'd2, 16'd1, 16, 33, 33);

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("ticketed_admission_fifo_top: match");
		else
			$display("ticketed_admission_fifo_top: mismatch");
		$finish;
	end

endmodule
